>>> rtl/orqm_pkg.sv
// shared constants and control types for the overwrite ring queue with mean
package orqm_pkg;

   // configuration defaults
   localparam int DEPTH_DEFAULT   = 5;
   localparam int VALUE_W         = 8;
   localparam int COUNT_W_DEFAULT = $clog2(DEPTH_DEFAULT + 1);

   // operation codes carried by an input item
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // controller states, one-hot
   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_DISPATCH = 7'b0000010,
      S_TAKE     = 7'b0000100,
      S_WRITE    = 7'b0001000,
      S_DSTART   = 7'b0010000,
      S_DIV      = 7'b0100000,
      S_LOAD     = 7'b1000000
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic take;
      logic write;
      logic div_start;
      logic load;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic op_pop;
      logic full;
      logic empty;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

>>> rtl/orqm_channels.sv
// valid/ready channel interfaces for request and response items
interface orqm_req_if;
   import orqm_pkg::*;

   logic               valid;
   logic               ready;
   logic               operation;
   logic [VALUE_W-1:0] value_in;

   modport source (output valid, output operation, output value_in, input ready);
   modport sink   (input valid, input operation, input value_in, output ready);
endinterface

interface orqm_rsp_if #(parameter int COUNT_W = orqm_pkg::COUNT_W_DEFAULT);
   import orqm_pkg::*;

   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] popped_value;
   logic               popped_valid;
   logic [VALUE_W-1:0] mean_value;
   logic [COUNT_W-1:0] held_count;

   modport source (output valid, output popped_value, output popped_valid,
                   output mean_value, output held_count, input ready);
   modport sink   (input valid, input popped_value, input popped_valid,
                   input mean_value, input held_count, output ready);
endinterface

>>> rtl/orqm_ram.sv
// generic single write port ram with registered read
module orqm_ram #(
   parameter int WIDTH = orqm_pkg::VALUE_W,
   parameter int DEPTH = orqm_pkg::DEPTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/orqm_divider.sv
// restoring divider, one quotient bit per cycle
module orqm_divider #(
   parameter int NUM_W = 12,
   parameter int DEN_W = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);
   import orqm_pkg::*;

   localparam int STEP_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W:0]    trial;
   logic              last_step;

   assign trial     = {rem_ff, num_ff[NUM_W-1]};
   assign last_step = (step_ff == STEP_W'(NUM_W - 1));

   // one shift and trial subtract per step
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, den_ff});
            num_in = {num_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            num_in = {num_ff[NUM_W-2:0], 1'b0};
         end
         step_in = step_ff + STEP_W'(1);
         if (last_step) begin
            busy_in = 1'b0;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   // operand and remainder registers
   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done = busy_ff && last_step;
   assign quot = num_ff;
endmodule

>>> rtl/orqm_datapath.sv
// queue pointers, running sum, entry store, divider and result register
module orqm_datapath #(
   parameter int DEPTH   = orqm_pkg::DEPTH_DEFAULT,
   parameter int COUNT_W = orqm_pkg::COUNT_W_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  orqm_pkg::cmd_type           cmd,
   output orqm_pkg::status_type        status,
   input  logic                        in_operation,
   input  logic [orqm_pkg::VALUE_W-1:0] in_value,
   input  logic                        out_ready,
   output logic                        out_valid,
   output logic [orqm_pkg::VALUE_W-1:0] out_popped_value,
   output logic                        out_popped_valid,
   output logic [orqm_pkg::VALUE_W-1:0] out_mean_value,
   output logic [COUNT_W-1:0]          out_held_count
);
   import orqm_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SUM_W = VALUE_W + COUNT_W;
   localparam int NUM_W = SUM_W + 1;
   localparam int DEN_W = COUNT_W + 1;

   // captured item
   logic               op_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [VALUE_W-1:0] popped_value_ff;
   logic               popped_valid_ff;

   // queue state
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [IDX_W-1:0]   tail_ff, tail_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;

   // result register
   logic               out_valid_ff, out_valid_in;
   logic [VALUE_W-1:0] out_popped_value_ff;
   logic               out_popped_valid_ff;
   logic [VALUE_W-1:0] out_mean_ff;
   logic [COUNT_W-1:0] out_count_ff;

   logic [VALUE_W-1:0] rd_data;
   logic               div_done;
   logic [NUM_W-1:0]   div_quot;
   logic [NUM_W-1:0]   div_num;
   logic [DEN_W-1:0]   div_den;

   // entry store, read port always follows the head
   orqm_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.write),
      .wr_addr (tail_ff),
      .wr_data (value_ff),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   // rounded mean: (2*sum + count) / (2*count)
   assign div_num = {sum_ff, 1'b0} + NUM_W'(count_ff);
   assign div_den = {count_ff, 1'b0};

   orqm_divider #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_divider (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // pointer, count and sum updates
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      if (cmd.take) begin
         head_in  = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);
         count_in = count_ff - COUNT_W'(1);
         sum_in   = sum_ff - SUM_W'(rd_data);
      end else if (cmd.write) begin
         tail_in  = (tail_ff == IDX_W'(DEPTH - 1)) ? '0 : tail_ff + IDX_W'(1);
         count_in = count_ff + COUNT_W'(1);
         sum_in   = sum_ff + SUM_W'(value_ff);
      end
   end

   // result valid flag, a new load wins over a take
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // item capture and popped value
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff           <= in_operation;
         value_ff        <= in_value;
         popped_value_ff <= '0;
         popped_valid_ff <= 1'b0;
      end else if (cmd.take && (op_ff == OP_POP)) begin
         popped_value_ff <= rd_data;
         popped_valid_ff <= 1'b1;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_popped_value_ff <= popped_value_ff;
         out_popped_valid_ff <= popped_valid_ff;
         out_mean_ff         <= (count_ff == '0) ? '0 : div_quot[VALUE_W-1:0];
         out_count_ff        <= count_ff;
      end
   end

   assign status.op_pop   = (op_ff == OP_POP);
   assign status.full     = (count_ff == COUNT_W'(DEPTH));
   assign status.empty    = (count_ff == '0);
   assign status.div_done = div_done;
   assign status.out_free = !out_valid_ff || out_ready;

   assign out_valid        = out_valid_ff;
   assign out_popped_value = out_popped_value_ff;
   assign out_popped_valid = out_popped_valid_ff;
   assign out_mean_value   = out_mean_ff;
   assign out_held_count   = out_count_ff;
endmodule

>>> rtl/orqm_controller.sv
// sequencing state machine for one item at a time
module orqm_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  orqm_pkg::status_type status,
   output orqm_pkg::cmd_type    cmd
);
   import orqm_pkg::*;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (status.op_pop) begin
               state_in = status.empty ? S_DSTART : S_TAKE;
            end else begin
               state_in = status.full ? S_TAKE : S_WRITE;
            end
         end
         S_TAKE: begin
            cmd.take = 1'b1;
            state_in = status.op_pop ? S_DSTART : S_WRITE;
         end
         S_WRITE: begin
            cmd.write = 1'b1;
            state_in  = S_DSTART;
         end
         S_DSTART: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (status.div_done) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign in_ready = (state_ff == S_IDLE);
endmodule

>>> rtl/overwrite_ring_queue_with_mean.sv
// ring queue with overwrite on full and rounded mean of the held values
// steps from accept to result: capture, dispatch, optional read, optional write,
// divider start, bit-serial mean division over NUM_W = 9 + clog2(DEPTH+1) bits, load;
// a push writes, a pop that finds an entry reads it out, a push on full also drops
// the oldest entry first; a new item is taken only after the last result is loaded
// a waiting result sits in its own register, so the next item is taken meanwhile;
// the next load waits until it is taken. reset (synchronous): queue empty, sum zero; store contents are not cleared
module overwrite_ring_queue_with_mean #(
   parameter int DEPTH = orqm_pkg::DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   orqm_req_if.sink     req_bus,
   orqm_rsp_if.source   rsp_bus
);
   import orqm_pkg::*;

   localparam int COUNT_W = $clog2(DEPTH + 1);

   cmd_type    cmd;
   status_type status;

   // sequencing
   orqm_controller u_controller (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_bus.valid),
      .in_ready (req_bus.ready),
      .status   (status),
      .cmd      (cmd)
   );

   // storage and arithmetic
   orqm_datapath #(
      .DEPTH   (DEPTH),
      .COUNT_W (COUNT_W)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .in_operation     (req_bus.operation),
      .in_value         (req_bus.value_in),
      .out_ready        (rsp_bus.ready),
      .out_valid        (rsp_bus.valid),
      .out_popped_value (rsp_bus.popped_value),
      .out_popped_valid (rsp_bus.popped_valid),
      .out_mean_value   (rsp_bus.mean_value),
      .out_held_count   (rsp_bus.held_count)
   );
endmodule
